// ----- src/fpa_pkg.sv -----
// Shared types, opcodes and sizing constants for the Q24.8 fixed-point ALU.
// No dependencies.
package fpa_pkg;

  localparam int FRAC_BITS   = 8;
  localparam int DIV_W       = 32 + FRAC_BITS;
  localparam int DIV_STAGES  = (DIV_W + 1) / 2;
  localparam int DIV_PAD     = 2 * DIV_STAGES;
  localparam int Q_DEPTH     = 4;
  localparam int Q_AW        = $clog2(Q_DEPTH);

  typedef enum logic [3:0] {
    OP_ADD  = 4'd0,  OP_SUB  = 4'd1,  OP_MUL  = 4'd2,  OP_DIV  = 4'd3,
    OP_LT   = 4'd4,  OP_GT   = 4'd5,  OP_LE   = 4'd6,  OP_GE   = 4'd7,
    OP_EQ   = 4'd8,  OP_NE   = 4'd9,  OP_INC  = 4'd10, OP_DEC  = 4'd11,
    OP_MIN  = 4'd12, OP_MAX  = 4'd13, OP_FINT = 4'd14, OP_TINT = 4'd15
  } op_t;

  typedef struct packed {
    op_t                 op;
    logic signed [31:0]  a;
    logic signed [31:0]  b;
    logic [DIV_PAD-1:0]  dvd;
    logic [31:0]         dvs;
    logic                neg;
    logic                dz;
  } item_t;

  typedef struct packed {
    item_t               it;
    logic signed [63:0]  prod;
    logic [32:0]         rem;
    logic [DIV_PAD-1:0]  quo;
  } stage_t;

  function automatic logic fits32(input logic signed [63:0] v);
    return (v[63:31] == {33{1'b0}}) || (v[63:31] == {33{1'b1}});
  endfunction

endpackage

// ----- src/fpa_front.sv -----
// Front end: takes requests and classifies them, prepares divider operands.
// Depends on fpa_pkg.
module fpa_front import fpa_pkg::*; (
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [3:0]         in_mode,
  input  logic signed [31:0] in_operand_a,
  input  logic signed [31:0] in_operand_b,
  output logic               push,
  output item_t              push_item,
  input  logic               q_full
);

  logic [31:0] mag_a;
  logic [31:0] mag_b;

  always_comb begin
    mag_a = in_operand_a[31] ? (32'd0 - in_operand_a) : in_operand_a;
    mag_b = in_operand_b[31] ? (32'd0 - in_operand_b) : in_operand_b;
    push_item.op  = op_t'(in_mode);
    push_item.a   = in_operand_a;
    push_item.b   = in_operand_b;
    push_item.dvd = DIV_PAD'(mag_a) << FRAC_BITS;
    push_item.dvs = mag_b;
    push_item.neg = in_operand_a[31] ^ in_operand_b[31];
    push_item.dz  = (op_t'(in_mode) == OP_DIV) && (in_operand_b == 32'sd0);
  end

  assign in_ready = !q_full;
  assign push     = in_valid && !q_full;

endmodule

// ----- src/fpa_queue.sv -----
// Short request queue between the front end and the execution pipeline.
// Depends on fpa_pkg.
module fpa_queue import fpa_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  push,
  input  item_t push_item,
  output logic  full,
  output logic  q_valid,
  input  logic  q_ready,
  output item_t q_item
);

  item_t         mem_r [Q_DEPTH];
  logic [Q_AW-1:0] wp_r, rp_r;
  logic [Q_AW:0]   cnt_r;
  logic            pop;

  assign full    = cnt_r == (Q_AW+1)'(Q_DEPTH);
  assign q_valid = cnt_r != '0;
  assign pop     = q_valid && q_ready;
  assign q_item  = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= push_item;
    end
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= wp_r + 1'b1;
      if (pop)  rp_r <= rp_r + 1'b1;
      cnt_r <= cnt_r + (Q_AW+1)'(push) - (Q_AW+1)'(pop);
    end
  end

endmodule

// ----- src/fpa_back.sv -----
// Execution pipeline: multiplier stage, radix-4 restoring divider stages,
// final result select and output register. Depends on fpa_pkg.
module fpa_back import fpa_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_valid,
  output logic               q_ready,
  input  item_t              q_item,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] out_value,
  output logic               out_compare_true,
  output logic               out_overflow,
  output logic               out_divide_by_zero
);

  stage_t s_r [DIV_STAGES+1];
  logic   v_r [DIV_STAGES+1];
  logic   advance;
  logic   out_valid_r;
  logic signed [31:0] val_r;
  logic   cmp_r, ovf_r, dz_r;

  logic signed [63:0] r64;
  logic   cmp_c;
  logic   arith_c;
  stage_t fin;

  function automatic stage_t div_step(input stage_t s);
    stage_t t;
    logic [32:0] sh;
    t = s;
    for (int i = 0; i < 2; i++) begin
      sh = {t.rem[31:0], t.it.dvd[DIV_PAD-1]};
      t.it.dvd = t.it.dvd << 1;
      if (sh >= {1'b0, t.it.dvs}) begin
        t.rem = sh - {1'b0, t.it.dvs};
        t.quo = {t.quo[DIV_PAD-2:0], 1'b1};
      end else begin
        t.rem = sh;
        t.quo = {t.quo[DIV_PAD-2:0], 1'b0};
      end
    end
    return t;
  endfunction

  assign advance = !out_valid_r || out_ready;
  assign q_ready = advance;

  always_ff @(posedge clk) begin
    if (advance) begin
      s_r[0].it   <= q_item;
      s_r[0].prod <= 64'(q_item.a) * 64'(q_item.b);
      s_r[0].rem  <= '0;
      s_r[0].quo  <= '0;
      for (int i = 1; i <= DIV_STAGES; i++) begin
        s_r[i] <= div_step(s_r[i-1]);
      end
      val_r <= r64[31:0];
      cmp_r <= cmp_c;
      ovf_r <= arith_c && !fits32(r64);
      dz_r  <= fin.it.dz;
    end
    if (!rst_n) begin
      for (int i = 0; i <= DIV_STAGES; i++) v_r[i] <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (advance) begin
      v_r[0] <= q_valid;
      for (int i = 1; i <= DIV_STAGES; i++) v_r[i] <= v_r[i-1];
      out_valid_r <= v_r[DIV_STAGES];
    end
  end

  always_comb begin
    logic signed [63:0] a64, b64, q64;
    fin     = s_r[DIV_STAGES];
    a64     = 64'(fin.it.a);
    b64     = 64'(fin.it.b);
    q64     = fin.it.neg ? -$signed(64'(fin.quo)) : $signed(64'(fin.quo));
    r64     = '0;
    cmp_c   = 1'b0;
    arith_c = 1'b1;
    case (fin.it.op)
      OP_ADD:  r64 = a64 + b64;
      OP_SUB:  r64 = a64 - b64;
      OP_MUL:  r64 = fin.prod >>> FRAC_BITS;
      OP_DIV:  r64 = fin.it.dz ? 64'sd0 : q64;
      OP_LT:   begin cmp_c = a64 <  b64; arith_c = 1'b0; end
      OP_GT:   begin cmp_c = a64 >  b64; arith_c = 1'b0; end
      OP_LE:   begin cmp_c = a64 <= b64; arith_c = 1'b0; end
      OP_GE:   begin cmp_c = a64 >= b64; arith_c = 1'b0; end
      OP_EQ:   begin cmp_c = a64 == b64; arith_c = 1'b0; end
      OP_NE:   begin cmp_c = a64 != b64; arith_c = 1'b0; end
      OP_INC:  r64 = a64 + 64'sd1;
      OP_DEC:  r64 = a64 - 64'sd1;
      OP_MIN:  r64 = (a64 < b64) ? a64 : b64;
      OP_MAX:  r64 = (a64 > b64) ? a64 : b64;
      OP_FINT: r64 = a64 <<< FRAC_BITS;
      OP_TINT: r64 = a64 >>> FRAC_BITS;
      default: r64 = '0;
    endcase
  end

  assign out_valid          = out_valid_r;
  assign out_value          = val_r;
  assign out_compare_true   = cmp_r;
  assign out_overflow       = ovf_r;
  assign out_divide_by_zero = dz_r;

endmodule

// ----- src/fixed_point_q24_8_alu.sv -----
// Top level of the signed Q24.8 fixed-point ALU.
// Depends on fpa_pkg, fpa_front, fpa_queue, fpa_back.
//
// Accepts one request per cycle and returns one result per request, in order.
// Every request passes a four-entry queue and a fixed pipeline of
// DIV_STAGES + 2 stages (22 for eight fractional bits), set by the divider,
// which resolves two quotient bits per stage; latency is therefore constant
// for all modes, and throughput is one request per cycle while the output
// is taken.
module fixed_point_q24_8_alu import fpa_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [3:0]         in_mode,
  input  logic signed [31:0] in_operand_a,
  input  logic signed [31:0] in_operand_b,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] out_value,
  output logic               out_compare_true,
  output logic               out_overflow,
  output logic               out_divide_by_zero
);

  logic  push, q_full, q_valid, q_ready;
  item_t push_item, q_item;

  fpa_front u_front (
    .in_valid, .in_ready, .in_mode, .in_operand_a, .in_operand_b,
    .push, .push_item, .q_full
  );

  fpa_queue u_queue (
    .clk, .rst_n, .push, .push_item, .full(q_full),
    .q_valid, .q_ready, .q_item
  );

  fpa_back u_back (
    .clk, .rst_n, .q_valid, .q_ready, .q_item,
    .out_valid, .out_ready, .out_value, .out_compare_true,
    .out_overflow, .out_divide_by_zero
  );

endmodule

// ----- tb/sv/tb_top.sv -----
// Testbench for the Q24.8 fixed-point ALU: directed corner requests, then random requests.
// A local predictor computes each expected result; depends on fpa_pkg and the RTL only.
`timescale 1ns / 1ps
module tb_top import fpa_pkg::*; ();

  typedef struct {
    logic signed [31:0] value;
    logic               cmp;
    logic               ovf;
    logic               dz;
  } alu_res_t;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_ready;
  logic [3:0]         in_mode;
  logic signed [31:0] in_operand_a;
  logic signed [31:0] in_operand_b;
  logic               out_valid;
  logic               out_ready;
  logic signed [31:0] out_value;
  logic               out_compare_true;
  logic               out_overflow;
  logic               out_divide_by_zero;

  alu_res_t expected_results[$];
  int       n_errors;
  int       n_checked;
  bit       calm;

  fixed_point_q24_8_alu u_top (.*);

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #50ms;
    $display("Timeout");
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  function automatic logic signed [63:0] floor_sra(input logic signed [63:0] v);
    return v >>> FRAC_BITS;
  endfunction

  function automatic alu_res_t alu_predict(input op_t op, input logic signed [31:0] a,
                                           input logic signed [31:0] b);
    alu_res_t r;
    logic signed [63:0] x, y, w;
    logic arith;
    x = a;
    y = b;
    w = 0;
    arith = 1'b1;
    r.cmp = 1'b0;
    r.dz = 1'b0;
    case (op)
      OP_ADD:  w = x + y;
      OP_SUB:  w = x - y;
      OP_MUL:  w = floor_sra(x * y);
      OP_DIV: begin
        if (y == 0) r.dz = 1'b1;
        else w = (x * (64'sd1 <<< FRAC_BITS)) / y;
      end
      OP_LT: begin r.cmp = x < y;  arith = 1'b0; end
      OP_GT: begin r.cmp = x > y;  arith = 1'b0; end
      OP_LE: begin r.cmp = x <= y; arith = 1'b0; end
      OP_GE: begin r.cmp = x >= y; arith = 1'b0; end
      OP_EQ: begin r.cmp = x == y; arith = 1'b0; end
      OP_NE: begin r.cmp = x != y; arith = 1'b0; end
      OP_INC:  w = x + 1;
      OP_DEC:  w = x - 1;
      OP_MIN:  w = (x < y) ? x : y;
      OP_MAX:  w = (x > y) ? x : y;
      OP_FINT: w = x * (64'sd1 <<< FRAC_BITS);
      default: w = floor_sra(x);
    endcase
    if (!arith) w = 0;
    r.value = w[31:0];
    r.ovf = (w < -64'sd2147483648) || (w > 64'sd2147483647);
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    n_errors++;
    $display("%0t mismatch %s: got %h expected %h", $realtime, what, got, want);
  endtask

  task automatic send_request(input op_t op, input logic signed [31:0] a,
                              input logic signed [31:0] b);
    int gap;
    if (!calm && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 8);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_mode <= op;
    in_operand_a <= a;
    in_operand_b <= b;
    expected_results.push_back(alu_predict(op, a, b));
    do @(posedge clk); while (!in_ready);
  endtask

  initial begin
    int stall;
    out_ready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      if (!calm && $urandom_range(0, 5) == 0) begin
        stall = $urandom_range(1, 8);
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    alu_res_t e;
    if (rst_n && out_valid && out_ready) begin
      if (expected_results.size() == 0) begin
        report_mismatch("unexpected result", out_value, 0);
      end else begin
        e = expected_results.pop_front();
        n_checked++;
        if (out_value !== e.value) report_mismatch("value", out_value, e.value);
        if (out_compare_true !== e.cmp) report_mismatch("compare_true", out_compare_true, e.cmp);
        if (out_overflow !== e.ovf) report_mismatch("overflow", out_overflow, e.ovf);
        if (out_divide_by_zero !== e.dz)
          report_mismatch("divide_by_zero", out_divide_by_zero, e.dz);
      end
    end
  end

  function automatic logic signed [31:0] pick_operand();
    case ($urandom_range(0, 7))
      0: return 32'sh7fffffff;
      1: return 32'sh80000000;
      2: return $signed($urandom_range(0, 1023)) - 512;
      3: return 0;
      default: return $urandom();
    endcase
  endfunction

  task automatic test_corners();
    logic signed [31:0] vals[6];
    vals = '{32'sh7fffffff, 32'sh80000000, 0, 1, -1, 32'sh100};
    for (int m = 0; m < 16; m++) send_request(op_t'(m), vals[m % 6], vals[(m + 1) % 6]);
    send_request(OP_DIV, 32'sh100, 0);
    send_request(OP_DIV, 32'sh80000000, -1);
    send_request(OP_MUL, 32'sh7fffffff, 32'sh7fffffff);
    send_request(OP_INC, 32'sh7fffffff, 0);
    send_request(OP_DEC, 32'sh80000000, 0);
    send_request(OP_FINT, 32'sh00800000, 0);
    send_request(OP_TINT, -1, 0);
    send_request(OP_EQ, 5, 5);
  endtask

  task automatic test_random(input int count);
    for (int i = 0; i < count; i++)
      send_request(op_t'($urandom_range(0, 15)), pick_operand(), pick_operand());
  endtask

  initial begin
    int wait_cycles;
    n_errors = 0;
    n_checked = 0;
    calm = 1'b0;
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_mode <= '0;
    in_operand_a <= '0;
    in_operand_b <= '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_corners();
    test_random(1150);
    calm = 1'b1;
    test_random(300);
    in_valid <= 1'b0;
    wait_cycles = 0;
    while (expected_results.size() != 0 && wait_cycles < 100000) begin
      @(posedge clk);
      wait_cycles++;
    end
    repeat (40) @(posedge clk);
    $display("Checked %0d results over all sixteen modes, corners and random operands",
             n_checked);
    if (n_errors == 0 && expected_results.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end
endmodule
